FILE: src/sync_length_frame_receiver_defines.svh
// Assertion macros for the sync/length frame receiver.
// Included by files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef SYNC_LENGTH_FRAME_RECEIVER_DEFINES_SVH
`define SYNC_LENGTH_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside reset.
`define SLFR_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("slfr assertion failed");

// Same check, with a message of the caller's choosing.
`define SLFR_ASSERT_MSG(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`else

`define SLFR_ASSERT(name, prop)
`define SLFR_ASSERT_MSG(name, prop, msg)

`endif

`endif

FILE: src/slfr_pkg.sv
// Shared types and constants of the sync/length frame receiver.
// No dependencies; used by every module of the block.
package slfr_pkg;

  // Frame geometry.
  localparam int unsigned MAX_FRAME_BYTES  = 1024;
  localparam int unsigned SYNC_BYTES       = 2;
  localparam int unsigned LENGTH_END_BYTES = 6;

  // Field widths.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned FLEN_W  = 11;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned SYNC_W  = 16;
  localparam int unsigned HDR_W   = 11;
  localparam int unsigned TICK_W  = 20;
  localparam int unsigned DECL_W  = 16;
  // Byte counter: the running total can reach the largest declared length
  // plus the largest header size.
  localparam int unsigned CNT_W   = 17;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_WORD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT = 2'd2;

  localparam logic [SYNC_W-1:0] SYNC_WORD_RST     = 16'hAA55;
  localparam logic [HDR_W-1:0]  HEADER_SIZE_RST   = 11'd6;
  localparam logic [TICK_W-1:0] TIMEOUT_LIMIT_RST = 20'd1000;

  // Word kinds.
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_NONE    = 3'd0;
  localparam logic [STAT_W-1:0] ST_DONE    = 3'd1;
  localparam logic [STAT_W-1:0] ST_SYNC    = 3'd2;
  localparam logic [STAT_W-1:0] ST_TIMEOUT = 3'd3;
  localparam logic [STAT_W-1:0] ST_LENGTH  = 3'd4;

  typedef struct packed {
    logic              req_type;
    logic [BYTE_W-1:0] rx_byte;
  } slfr_item_t;

  typedef struct packed {
    logic              wr_valid;
    logic [IDX_W-1:0]  wr_index;
    logic [BYTE_W-1:0] wr_data;
    logic [STAT_W-1:0] status;
    logic [FLEN_W-1:0] frame_length;
  } slfr_result_t;

  typedef struct packed {
    logic [SYNC_W-1:0] sync_word;
    logic [HDR_W-1:0]  header_size;
    logic [TICK_W-1:0] timeout_limit;
  } slfr_cfg_t;

endpackage

FILE: src/slfr_cfg.sv
// Configuration registers of the sync/length frame receiver.
// Depends on slfr_pkg for the register indexes, widths and reset values.
module slfr_cfg import slfr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output slfr_cfg_t             cfg_o
);

  slfr_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SYNC_WORD:     cfg_d.sync_word     = cfg_wdata_i[SYNC_W-1:0];
        REG_HEADER_SIZE:   cfg_d.header_size   = cfg_wdata_i[HDR_W-1:0];
        REG_TIMEOUT_LIMIT: cfg_d.timeout_limit = cfg_wdata_i[TICK_W-1:0];
        default: begin
          // Writes to unused indexes are dropped.
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_word     <= SYNC_WORD_RST;
      cfg_q.header_size   <= HEADER_SIZE_RST;
      cfg_q.timeout_limit <= TIMEOUT_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/slfr_step.sv
// Framing state and per-word next-state logic of the sync/length frame receiver.
// Depends on slfr_pkg for the word, result and configuration types.
module slfr_step import slfr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         fire_i,
  input  slfr_item_t   item_i,
  input  slfr_cfg_t    cfg_i,
  output slfr_result_t res_o
);

  localparam logic [1:0] PH_SYNC = 2'd0;
  localparam logic [1:0] PH_HEAD = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  localparam logic [CNT_W-1:0]  SYNC_CNT  = CNT_W'(SYNC_BYTES);
  localparam logic [CNT_W-1:0]  LEN_CNT   = CNT_W'(LENGTH_END_BYTES);
  localparam logic [CNT_W-1:0]  LEN_POS   = CNT_W'(LENGTH_END_BYTES - 2);
  localparam logic [CNT_W-1:0]  MAX_TOTAL = CNT_W'(MAX_FRAME_BYTES);
  localparam logic [TICK_W-1:0] TICK_MAX  = '1;

  logic [1:0]        phase_q, phase_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DECL_W-1:0] decl_q, decl_d;
  logic [BYTE_W-1:0] held_q, held_d;
  logic [TICK_W-1:0] idle_q, idle_d;
  logic              in_frame_q, in_frame_d;

  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  head_total;
  logic [DECL_W-1:0] head_decl;
  logic              drop;

  assign cnt_inc    = cnt_q + 1'b1;
  assign total      = CNT_W'(decl_q) + CNT_W'(cfg_i.header_size);
  assign head_decl  = {held_q, item_i.rx_byte};
  assign head_total = CNT_W'(head_decl) + CNT_W'(cfg_i.header_size);

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    decl_d     = decl_q;
    held_d     = held_q;
    idle_d     = idle_q;
    in_frame_d = in_frame_q;
    drop       = 1'b0;
    res_o      = '0;

    if (fire_i) begin
      if (item_i.req_type == REQ_TICK) begin
        if (in_frame_q) begin
          if (idle_q >= cfg_i.timeout_limit) begin
            drop         = 1'b1;
            res_o.status = ST_TIMEOUT;
          end else if (idle_q != TICK_MAX) begin
            idle_d = idle_q + 1'b1;
          end
        end
      end else begin
        idle_d         = '0;
        in_frame_d     = 1'b1;
        cnt_d          = cnt_inc;
        res_o.wr_valid = 1'b1;
        res_o.wr_index = cnt_q[IDX_W-1:0];
        res_o.wr_data  = item_i.rx_byte;
        case (phase_q)
          PH_SYNC: begin
            if (cnt_inc == SYNC_CNT) begin
              if ({held_q, item_i.rx_byte} != cfg_i.sync_word) begin
                drop         = 1'b1;
                res_o.status = ST_SYNC;
              end else begin
                phase_d = PH_HEAD;
              end
            end else begin
              held_d = item_i.rx_byte;
            end
          end
          PH_HEAD: begin
            // The length field is the two bytes that end at LENGTH_END_BYTES, high byte first.
            if (cnt_q == LEN_POS) begin
              held_d = item_i.rx_byte;
            end
            if (cnt_inc == LEN_CNT) begin
              decl_d = head_decl;
              if (head_total <= LEN_CNT || head_total > MAX_TOTAL) begin
                drop         = 1'b1;
                res_o.status = ST_LENGTH;
              end else begin
                phase_d = PH_BODY;
              end
            end
          end
          default: begin
            if (cnt_inc >= total) begin
              drop               = 1'b1;
              res_o.status       = ST_DONE;
              res_o.frame_length = cnt_inc[FLEN_W-1:0];
            end
          end
        endcase
      end
    end

    if (drop) begin
      phase_d    = PH_SYNC;
      cnt_d      = '0;
      decl_d     = '0;
      held_d     = '0;
      idle_d     = '0;
      in_frame_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SYNC;
      cnt_q      <= '0;
      decl_q     <= '0;
      held_q     <= '0;
      idle_q     <= '0;
      in_frame_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      decl_q     <= decl_d;
      held_q     <= held_d;
      idle_q     <= idle_d;
      in_frame_q <= in_frame_d;
    end
  end

endmodule

FILE: src/sync_length_frame_receiver.sv
// Top level of the sync/length frame receiver: input and result registers
// around the framing step. Depends on slfr_pkg, slfr_cfg, slfr_step and the defines header.
//
// Usage. The input channel (in_valid_i, in_stall_o, in_data_i) carries one word
// per item: a received byte or a timer tick. The output channel (out_valid_o,
// out_stall_i, out_data_o) returns exactly one result word per input word: the
// byte with its buffer index for storage, plus a status and, on completion,
// the frame length. A word is moved at a rising edge with valid high and stall low.
// A word accepted at an edge is captured in the input register, then processed
// and loaded into the result register once the result register can advance.
// Throughput is one word per cycle while the output is not stalled; the framing
// state is updated in the single combinational step between the two registers.
// When the receiver stalls, the result register holds its word and the input
// register keeps its word; in_stall_o rises only while both are full and the
// output is stalled. Reset empties both registers, returns the framing state to
// the sync phase and loads the registers with their default values.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i.
`include "sync_length_frame_receiver_defines.svh"

module sync_length_frame_receiver import slfr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  slfr_item_t            in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output slfr_result_t          out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  slfr_cfg_t    cfg;
  slfr_result_t step_res;

  logic         in_valid_q;
  slfr_item_t   in_data_q;
  logic         out_valid_q;
  slfr_result_t out_data_q;
  logic         advance;
  logic         in_accept;
  logic         fire;

  assign advance   = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept = in_valid_i && !in_stall_o;
  assign fire      = in_valid_q && advance;

  slfr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  slfr_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_data_q),
    .cfg_i  (cfg),
    .res_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        in_valid_q  <= in_accept;
        out_valid_q <= in_valid_q;
      end else if (!in_valid_q) begin
        in_valid_q <= in_accept;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_data_q <= in_data_i;
    end
    if (fire) begin
      out_data_q <= step_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The input register only holds back while the result register is blocked.
  `SLFR_ASSERT(a_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i))
  // A completed frame always comes with its last byte.
  `SLFR_ASSERT_MSG(a_done_len,
    (out_valid_o && out_data_o.status == ST_DONE) |-> out_data_o.wr_valid,
    "frame completion without byte")
  // Tick results carry no byte and no length; only ticks can time out.
  `SLFR_ASSERT_MSG(a_tick_result,
    (out_valid_o && !out_data_o.wr_valid) |->
      (out_data_o.frame_length == '0 && out_data_o.wr_index == '0 &&
       (out_data_o.status == ST_NONE || out_data_o.status == ST_TIMEOUT)),
    "tick result carries byte fields")
  // A word waiting in the input register while the output drains moves on next edge.
  `SLFR_ASSERT(a_drain, (in_valid_q && advance) |=> out_valid_o)

endmodule

FILE: tb/sv/sync_length_frame_receiver_tb.sv
// Self-checking testbench for sync_length_frame_receiver: directed and random framing traffic
// with random idling on both channels, checked word by word against an in-bench predictor.
// Depends on slfr_pkg and the RTL of the block only.
module sync_length_frame_receiver_tb import slfr_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SEG_WORDS   = 120;
  localparam int unsigned NUM_SEGS    = 6;
  localparam int unsigned HOLD_CYCLES = 90;
  // Index with no register behind it; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum logic [1:0] {PH_SYNC, PH_HEAD, PH_BODY} frame_phase_e;

  class frame_tracker;
    logic [SYNC_W-1:0] sync_word;
    logic [HDR_W-1:0]  header_size;
    logic [TICK_W-1:0] timeout_limit;
    frame_phase_e      phase;
    logic [CNT_W-1:0]  byte_count;
    logic [DECL_W-1:0] declared_length;
    logic [BYTE_W-1:0] held_byte;
    logic [TICK_W-1:0] idle_ticks;
    bit                in_frame;
    slfr_result_t      expected_words[$];
    int unsigned       mismatches;
    int unsigned       status_count[5];

    function new();
      sync_word     = SYNC_WORD_RST;
      header_size   = HEADER_SIZE_RST;
      timeout_limit = TIMEOUT_LIMIT_RST;
      mismatches    = 0;
      foreach (status_count[i]) status_count[i] = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      phase           = PH_SYNC;
      byte_count      = '0;
      declared_length = '0;
      held_byte       = '0;
      idle_ticks      = '0;
      in_frame        = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SYNC_WORD:     sync_word     = data[SYNC_W-1:0];
        REG_HEADER_SIZE:   header_size   = data[HDR_W-1:0];
        REG_TIMEOUT_LIMIT: timeout_limit = data[TICK_W-1:0];
        default: ;
      endcase
    endfunction

    // Advances the framing state by one accepted word and queues the result it causes.
    function void note_word(slfr_item_t w);
      slfr_result_t     r;
      logic [CNT_W-1:0] pos;
      logic [CNT_W-1:0] total;
      r = '0;
      if (w.req_type == REQ_TICK) begin
        if (in_frame) begin
          if (idle_ticks >= timeout_limit) begin
            clear_frame();
            r.status = ST_TIMEOUT;
          end else if (idle_ticks != '1) begin
            idle_ticks = idle_ticks + 1'b1;
          end
        end
      end else begin
        pos        = byte_count;
        idle_ticks = '0;
        in_frame   = 1'b1;
        byte_count = byte_count + 1'b1;
        case (phase)
          PH_SYNC: begin
            if (byte_count == SYNC_BYTES) begin
              if ({held_byte, w.rx_byte} != sync_word) begin
                clear_frame();
                r.status = ST_SYNC;
              end else begin
                phase = PH_HEAD;
              end
            end else begin
              held_byte = w.rx_byte;
            end
          end
          PH_HEAD: begin
            if (pos == LENGTH_END_BYTES - 2) held_byte = w.rx_byte;
            if (byte_count == LENGTH_END_BYTES) begin
              declared_length = {held_byte, w.rx_byte};
              total = declared_length + header_size;
              if (total <= LENGTH_END_BYTES || total > MAX_FRAME_BYTES) begin
                clear_frame();
                r.status = ST_LENGTH;
              end else begin
                phase = PH_BODY;
              end
            end
          end
          default: begin
            total = declared_length + header_size;
            if (byte_count >= total) begin
              r.frame_length = byte_count[FLEN_W-1:0];
              clear_frame();
              r.status = ST_DONE;
            end
          end
        endcase
        r.wr_valid = 1'b1;
        r.wr_index = pos[IDX_W-1:0];
        r.wr_data  = w.rx_byte;
      end
      status_count[r.status]++;
      expected_words.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(slfr_result_t got);
      slfr_result_t want;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: %p", got);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("wr_valid", 32'(want.wr_valid), 32'(got.wr_valid));
      compare_field("wr_index", 32'(want.wr_index), 32'(got.wr_index));
      compare_field("wr_data", 32'(want.wr_data), 32'(got.wr_data));
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("frame_length", 32'(want.frame_length), 32'(got.frame_length));
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  slfr_item_t            in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  slfr_result_t          out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  frame_tracker tracker = new();

  int unsigned cycle_count    = 0;
  int unsigned words_sent     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned stray_tick_pct = 0;
  int          big_left       = 2;
  bit          hold_armed     = 1'b0;
  bit          hold_done      = 1'b0;
  int unsigned hold_left      = 0;

  sync_length_frame_receiver uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver side: random stalls, plus one long hold-off once armed so the block backs up.
  always @(posedge clk) begin
    if (hold_armed && !hold_done && hold_left == 0) hold_left = HOLD_CYCLES;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
      if (hold_left == 0) hold_done = 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_word(out_data);
  end

  task automatic send_word(input slfr_item_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_word(w);
    words_sent++;
  endtask

  task automatic send_ticks(input int n);
    slfr_item_t w;
    w.req_type = REQ_TICK;
    for (int i = 0; i < n; i++) begin
      w.rx_byte = BYTE_W'($urandom_range(255));
      send_word(w);
    end
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    slfr_item_t w;
    w.req_type = REQ_BYTE;
    w.rx_byte  = b;
    send_word(w);
    if ($urandom_range(99) < stray_tick_pct) send_ticks(int'($urandom_range(1, 3)));
  endtask

  task automatic send_header(input logic [DECL_W-1:0] decl);
    send_byte(tracker.sync_word[15:8]);
    send_byte(tracker.sync_word[7:0]);
    send_byte(BYTE_W'($urandom_range(255)));
    send_byte(BYTE_W'($urandom_range(255)));
    send_byte(decl[15:8]);
    send_byte(decl[7:0]);
  endtask

  // Mostly well-formed frames with random content; the rest are broken or noise.
  task automatic send_random_frame();
    int                pick;
    int                lo;
    int                total;
    int                n;
    logic [DECL_W-1:0] decl;
    logic [BYTE_W-1:0] second;
    pick = int'($urandom_range(99));
    lo   = (tracker.header_size > 7) ? int'(tracker.header_size) : 7;
    if (pick < 70 && lo <= MAX_FRAME_BYTES && (lo <= 64 || big_left > 0)) begin
      total = (lo > 64) ? lo : lo + int'($urandom_range(24));
      if (lo > 64) big_left--;
      decl = DECL_W'(total - int'(tracker.header_size));
      send_header(decl);
      for (int i = LENGTH_END_BYTES; i < total; i++) send_byte(BYTE_W'($urandom_range(255)));
    end else if (pick < 80) begin
      if ($urandom_range(1) == 0 && tracker.header_size <= LENGTH_END_BYTES)
        decl = DECL_W'($urandom_range(LENGTH_END_BYTES - tracker.header_size));
      else
        decl = DECL_W'($urandom_range(65535, 1025));
      send_header(decl);
    end else if (pick < 88) begin
      second = BYTE_W'($urandom_range(255));
      if (second == tracker.sync_word[7:0]) second = second ^ 8'h01;
      send_byte(tracker.sync_word[15:8]);
      send_byte(second);
    end else if (pick < 95) begin
      // Partial frame, then ticks; they run out the tick limit only when it is 40 or less.
      n = int'($urandom_range(1, 5));
      send_byte(tracker.sync_word[15:8]);
      for (int i = 1; i < n; i++)
        send_byte((i == 1) ? tracker.sync_word[7:0] : 8'($urandom_range(255)));
      send_ticks((tracker.timeout_limit <= 40) ? int'(tracker.timeout_limit) + 1
                                               : int'($urandom_range(1, 8)));
    end else begin
      n = int'($urandom_range(1, 4));
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(1) == 0) send_ticks(1);
        else send_byte(BYTE_W'($urandom_range(255)));
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic set_config(input logic [SYNC_W-1:0] sync_word, input logic [HDR_W-1:0] hdr,
                            input logic [TICK_W-1:0] limit);
    write_reg(REG_SYNC_WORD, CFG_DATA_W'(sync_word));
    write_reg(REG_HEADER_SIZE, CFG_DATA_W'(hdr));
    write_reg(REG_TIMEOUT_LIMIT, CFG_DATA_W'(limit));
    cfg_we <= 1'b0;
  endtask

  // Every word yields one result, so an empty expectation queue means the block is idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure_segment(input int seg);
    case (seg)
      0: begin
        write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(20'hFFFFF)));
        set_config(SYNC_W'($urandom_range(16'hFFFF)), 11'd6, 20'd2);
      end
      1: set_config(16'h0000, 11'd0, 20'd0);
      2: set_config(16'hFFFF, 11'd200, 20'd5);
      3: set_config(SYNC_W'($urandom_range(16'hFFFF)), 11'd2047, 20'hFFFFF);
      4: set_config(SYNC_W'($urandom_range(16'hFFFF)), HDR_W'($urandom_range(40)),
                    TICK_W'($urandom_range(20)));
      default: set_config(SYNC_W'($urandom_range(16'hFFFF)), 11'd7, 20'd1);
    endcase
  endtask

  initial begin
    int unsigned target;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset register values, then with a timeout limit of zero.
    send_ticks(1);
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'h00);
    send_ticks(1);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_header(16'h0000);
    send_header(16'hFFFF);
    drain();
    set_config(SYNC_WORD_RST, HEADER_SIZE_RST, 20'd0);
    send_byte(8'hAA);
    send_ticks(1);
    drain();

    stray_tick_pct = 6;
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      send_idle_pct = (seg < 2) ? 24 : (seg < 4) ? 46 : 0;
      recv_idle_pct = (seg < 2) ? 46 : (seg < 4) ? 24 : 0;
      configure_segment(seg);
      if (seg == 4) hold_armed = 1'b1;
      target = words_sent + SEG_WORDS;
      while (words_sent < target) send_random_frame();
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Covered %0d words: %0d frames done, %0d sync errors, %0d timeouts, %0d length errors",
             words_sent, tracker.status_count[ST_DONE], tracker.status_count[ST_SYNC],
             tracker.status_count[ST_TIMEOUT], tracker.status_count[ST_LENGTH]);
    $display("Register sets: reset values and %0d written sets; long receiver hold-off done: %0d",
             NUM_SEGS + 1, hold_done);
    if (tracker.mismatches == 0 && tracker.expected_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
